### rtl/core/positional_sequence_store_macros.svh
// assertion helpers shared by the rtl, clocked on clk, idle during reset
`ifndef POSITIONAL_SEQUENCE_STORE_MACROS_SVH
`define POSITIONAL_SEQUENCE_STORE_MACROS_SVH

// same-cycle implication
`define PSS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pss check failed");

// next-cycle implication
`define PSS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pss check failed");

`endif

### rtl/core/pss_pkg.sv
package pss_pkg;

	// store geometry (capacity is a power of two so slot math wraps freely)
	localparam int CAPACITY = 1024;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int DATA_W   = 32;
	localparam int POS_W    = 11;
	localparam int ACT_W    = 3;
	localparam int ST_W     = 2;
	localparam int CMP_W    = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

	// action codes
	localparam logic [ACT_W-1:0] ACT_APPEND = 3'd0;
	localparam logic [ACT_W-1:0] ACT_INSERT = 3'd1;
	localparam logic [ACT_W-1:0] ACT_DELETE = 3'd2;
	localparam logic [ACT_W-1:0] ACT_ROTATE = 3'd3;
	localparam logic [ACT_W-1:0] ACT_READ   = 3'd4;

	// status codes
	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd3;

	// memory access from the sequencer
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [DATA_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	// one finished result
	typedef struct packed {
		logic [ST_W-1:0]          status;
		logic signed [DATA_W-1:0] read_value;
		logic [CNT_W-1:0]         element_count;
	} result_t;

endpackage

### rtl/core/positional_sequence_store.sv
// Ordered store of up to 1024 signed 32-bit values kept as a ring in one
// simple dual-port RAM. Each transfer in carries one action and gives exactly
// one transfer out (status, read value, element count after the action).
// One item is handled at a time. Append and rejected or unknown actions go
// straight to the result; read and rotate first read the RAM; insert and
// delete shift the tail of the sequence, moving one entry per cycle
// through the single RAM write port, and insert then writes the new value.
// The result sits in an output register, so the next item is taken while an
// earlier result waits. There is no clearing pass after reset; the store
// content is only ever read where it was written.
module positional_sequence_store import pss_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [ACT_W-1:0]         action,
	input  logic [POS_W-1:0]         position,
	input  logic signed [DATA_W-1:0] value,
	input  logic                     rotate_left,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [ST_W-1:0]          status,
	output logic signed [DATA_W-1:0] read_value,
	output logic [CNT_W-1:0]         element_count
);

	mem_req_t          mem_req;
	logic [DATA_W-1:0] mem_rdata;
	logic              res_valid;
	logic              res_ready;
	result_t           res;
	logic              out_valid_q;
	result_t           out_q;

	// sequencer
	pss_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.position    (position),
		.value       (value),
		.rotate_left (rotate_left),
		.mem_req     (mem_req),
		.mem_rdata   (mem_rdata),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res)
	);

	// element storage
	pss_ram #(
		.DEPTH (CAPACITY),
		.WIDTH (DATA_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.re    (mem_req.re),
		.raddr (mem_req.raddr),
		.rdata (mem_rdata)
	);

	// output register
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_q.status;
	assign read_value    = out_q.read_value;
	assign element_count = out_q.element_count;

endmodule

### rtl/core/pss_ram.sv
module pss_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/core/pss_ctrl.sv
`include "positional_sequence_store_macros.svh"

module pss_ctrl import pss_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [ACT_W-1:0]  action,
	input  logic [POS_W-1:0]  position,
	input  logic [DATA_W-1:0] value,
	input  logic              rotate_left,
	output mem_req_t          mem_req,
	input  logic [DATA_W-1:0] mem_rdata,
	output logic              res_valid,
	input  logic              res_ready,
	output result_t           res
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SHIFT,
		S_DRAIN,
		S_FIN,
		S_READ,
		S_RESP
	} state_t;

	state_t            state_q;
	logic [ADDR_W-1:0] head_q;
	logic [CNT_W-1:0]  count_q;
	logic [ACT_W-1:0]  op_q;
	logic [DATA_W-1:0] val_q;
	logic [CNT_W-1:0]  idx_q;
	logic [CNT_W-1:0]  rem_q;
	logic              down_q;
	logic [ADDR_W-1:0] fin_addr_q;
	logic [ST_W-1:0]   status_q;
	logic [DATA_W-1:0] rd_val_q;
	logic              pend_s1;
	logic [ADDR_W-1:0] waddr_s1;

	logic              acc;
	logic              full;
	logic              empty;
	logic              pos_ok_ins;
	logic              pos_ok_acc;
	logic [CNT_W-1:0]  pos_m1;
	logic [CNT_W-1:0]  ins_rem;
	logic [CNT_W-1:0]  del_rem;
	logic [ADDR_W-1:0] rot_src;
	logic [ADDR_W-1:0] rot_dst;
	logic [ADDR_W-1:0] rot_head;

	// logical to physical slot
	function automatic logic [ADDR_W-1:0] slot(input logic [ADDR_W-1:0] h,
	                                           input logic [CNT_W-1:0] l);
		return h + l[ADDR_W-1:0];
	endfunction

	assign acc        = in_valid && in_ready;
	assign in_ready   = (state_q == S_IDLE);
	assign full       = (count_q == CNT_W'(CAPACITY));
	assign empty      = (count_q == '0);
	assign pos_m1     = CNT_W'(position - POS_W'(1));
	assign pos_ok_ins = (position != '0) &&
	                    (CMP_W'(position) <= CMP_W'(count_q) + CMP_W'(1));
	assign pos_ok_acc = (position != '0) && (CMP_W'(position) <= CMP_W'(count_q));
	assign ins_rem    = count_q - pos_m1;
	assign del_rem    = count_q - CNT_W'(position);

	// rotate moves one entry across the ring and steps the head
	always_comb begin
		if (rotate_left) begin
			rot_src  = head_q;
			rot_dst  = slot(head_q, count_q);
			rot_head = head_q + ADDR_W'(1);
		end else begin
			rot_src  = slot(head_q, count_q - CNT_W'(1));
			rot_dst  = head_q - ADDR_W'(1);
			rot_head = head_q - ADDR_W'(1);
		end
	end

	// memory port steering
	always_comb begin
		mem_req = '0;
		if (pend_s1) begin
			mem_req.we    = 1'b1;
			mem_req.waddr = waddr_s1;
			mem_req.wdata = mem_rdata;
		end
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					priority if (action == ACT_APPEND && !full) begin
						mem_req.we    = 1'b1;
						mem_req.waddr = slot(head_q, count_q);
						mem_req.wdata = value;
					end else if (action == ACT_ROTATE && !empty) begin
						mem_req.re    = 1'b1;
						mem_req.raddr = rot_src;
					end else if (action == ACT_READ && !empty && pos_ok_acc) begin
						mem_req.re    = 1'b1;
						mem_req.raddr = slot(head_q, pos_m1);
					end else begin
						mem_req.re = 1'b0;
					end
				end
			end
			S_SHIFT: begin
				mem_req.re    = 1'b1;
				mem_req.raddr = slot(head_q, idx_q);
			end
			S_FIN: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = fin_addr_q;
				mem_req.wdata = val_q;
			end
			S_DRAIN, S_READ, S_RESP: begin
				mem_req.re = 1'b0;
			end
			default: begin
				mem_req.re = 1'b0;
			end
		endcase
	end

	assign res_valid = (state_q == S_RESP);
	assign res       = '{status: status_q, read_value: rd_val_q, element_count: count_q};

	// sequencer and bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			head_q   <= '0;
			count_q  <= '0;
			pend_s1  <= 1'b0;
			op_q     <= ACT_APPEND;
			status_q <= ST_OK;
			rd_val_q <= '0;
		end else begin
			pend_s1 <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						op_q     <= action;
						val_q    <= value;
						status_q <= ST_OK;
						rd_val_q <= '0;
						state_q  <= S_RESP;
						unique case (action)
							ACT_APPEND: begin
								if (full) begin
									status_q <= ST_FULL;
								end else begin
									count_q <= count_q + CNT_W'(1);
								end
							end
							ACT_INSERT: begin
								if (full) begin
									status_q <= ST_FULL;
								end else if (!pos_ok_ins) begin
									status_q <= ST_RANGE;
								end else begin
									idx_q      <= count_q - CNT_W'(1);
									rem_q      <= ins_rem;
									down_q     <= 1'b1;
									fin_addr_q <= slot(head_q, pos_m1);
									state_q    <= (ins_rem == '0) ? S_FIN : S_SHIFT;
								end
							end
							ACT_DELETE: begin
								if (empty) begin
									status_q <= ST_EMPTY;
								end else if (!pos_ok_acc) begin
									status_q <= ST_RANGE;
								end else if (del_rem == '0) begin
									count_q <= count_q - CNT_W'(1);
								end else begin
									idx_q   <= CNT_W'(position);
									rem_q   <= del_rem;
									down_q  <= 1'b0;
									state_q <= S_SHIFT;
								end
							end
							ACT_ROTATE: begin
								if (empty) begin
									status_q <= ST_EMPTY;
								end else begin
									pend_s1  <= 1'b1;
									waddr_s1 <= rot_dst;
									head_q   <= rot_head;
									state_q  <= S_DRAIN;
								end
							end
							ACT_READ: begin
								if (empty) begin
									status_q <= ST_EMPTY;
								end else if (!pos_ok_acc) begin
									status_q <= ST_RANGE;
								end else begin
									state_q <= S_READ;
								end
							end
							default: begin
								status_q <= ST_OK;
							end
						endcase
					end
				end
				// one entry moves per cycle, its write lands in the cycle after its read
				S_SHIFT: begin
					pend_s1  <= 1'b1;
					waddr_s1 <= down_q ? slot(head_q, idx_q + CNT_W'(1))
					                   : slot(head_q, idx_q - CNT_W'(1));
					idx_q    <= down_q ? idx_q - CNT_W'(1) : idx_q + CNT_W'(1);
					rem_q    <= rem_q - CNT_W'(1);
					if (rem_q == CNT_W'(1)) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (op_q == ACT_INSERT) begin
						state_q <= S_FIN;
					end else begin
						if (op_q == ACT_DELETE) begin
							count_q <= count_q - CNT_W'(1);
						end
						state_q <= S_RESP;
					end
				end
				S_FIN: begin
					count_q <= count_q + CNT_W'(1);
					state_q <= S_RESP;
				end
				S_READ: begin
					rd_val_q <= mem_rdata;
					state_q  <= S_RESP;
				end
				S_RESP: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`PSS_ASSERT_IMP(a_count_max, 1'b1, count_q <= CNT_W'(CAPACITY))
	`PSS_ASSERT_IMP(a_pend_state, pend_s1, state_q == S_SHIFT || state_q == S_DRAIN)
	`PSS_ASSERT_NXT(a_resp_hold, res_valid && !res_ready, res_valid && $stable(count_q))
	`PSS_ASSERT_IMP(a_idle_quiet, in_ready, !pend_s1 && !res_valid)

endmodule
